// File: design/kbr_pkg.sv
// shared types, key tables and constants for the keyboard scancode ring
`default_nettype none
package kbr_pkg;

    typedef enum logic [1:0] {
        KIND_SCAN = 2'd0,
        KIND_READ = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    localparam int          KEY_W     = 7;
    localparam int          ASCII_W   = 8;
    localparam int          WORD_W    = KEY_W + ASCII_W;
    localparam int          MOD_W     = 3;
    localparam int          TABLE_LEN = 58;
    localparam int          TAB_IDX_W = $clog2(TABLE_LEN);

    localparam logic [6:0]  SC_LSHIFT  = 7'h2A;
    localparam logic [6:0]  SC_RSHIFT  = 7'h36;
    localparam logic [6:0]  SC_CTRL    = 7'h1D;
    localparam logic [2:0]  MOD_RSHIFT = 3'h1;
    localparam logic [2:0]  MOD_LSHIFT = 3'h2;
    localparam logic [2:0]  MOD_CTRL   = 3'h4;
    localparam logic [7:0]  CTRL_MASK  = 8'h1F;
    localparam logic [7:0]  CASE_BIT   = 8'h20;
    localparam logic [7:0]  ASCII_LO_A = 8'h61;
    localparam logic [7:0]  ASCII_LO_Z = 8'h7A;

    localparam logic [7:0] LOWER_TAB [0:TABLE_LEN-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] UPPER_TAB [0:TABLE_LEN-1] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
        8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    typedef struct packed {
        logic scan;
        logic load_none;
        logic load_ring;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic empty;
    } t_sts;

endpackage
`default_nettype wire

// File: design/kbr_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module kbr_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: design/kbr_ctrl.sv
// controller state machine: input/output handshakes and datapath commands
`default_nettype none
module kbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_kind,
    output logic               o_valid,
    input  wire logic          i_ready,
    output kbr_pkg::t_cmd      o_cmd,
    input  wire kbr_pkg::t_sts i_sts
);
    import kbr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_pop, n_pop;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_pop       = r_pop;
        n_out_valid = r_out_valid;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_kind))
                        KIND_SCAN: begin
                            cmd.scan    = 1'b1;
                            n_state     = S_OUT;
                            n_out_valid = 1'b1;
                        end
                        KIND_READ, KIND_PEEK: begin
                            n_pop = (t_kind'(i_kind) == KIND_READ);
                            if (i_sts.empty) begin
                                cmd.load_none = 1'b1;
                                n_state       = S_OUT;
                                n_out_valid   = 1'b1;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            cmd.load_none = 1'b1;
                            n_state       = S_OUT;
                            n_out_valid   = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                cmd.load_ring = 1'b1;
                cmd.pop       = r_pop;
                n_state       = S_OUT;
                n_out_valid   = 1'b1;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pop       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pop       <= n_pop;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;
endmodule
`default_nettype wire

// File: design/kbr_dp.sv
// datapath: modifier flags, key translation, ring pointers and result registers
`default_nettype none
module kbr_dp #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire kbr_pkg::t_cmd             i_cmd,
    output kbr_pkg::t_sts                  o_sts,
    input  wire logic [7:0]                i_scancode,
    output logic                           o_we,
    output logic [$clog2(RING_DEPTH)-1:0]  o_waddr,
    output logic [kbr_pkg::WORD_W-1:0]     o_wdata,
    output logic [$clog2(RING_DEPTH)-1:0]  o_raddr,
    input  wire logic [kbr_pkg::WORD_W-1:0] i_rdata,
    output logic                           o_key_valid,
    output logic [kbr_pkg::KEY_W-1:0]      o_key_scan,
    output logic [kbr_pkg::ASCII_W-1:0]    o_key_ascii,
    output logic [kbr_pkg::MOD_W-1:0]      o_modifiers,
    output logic                           o_dropped
);
    import kbr_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]   r_wr_idx, n_wr_idx;
    logic [MOD_W-1:0]   r_mods, n_mods;
    logic               r_key_valid;
    logic [KEY_W-1:0]   r_key_scan;
    logic [ASCII_W-1:0] r_key_ascii;
    logic               r_dropped;

    logic [KEY_W-1:0]   key;
    logic               rel;
    logic [MOD_W-1:0]   mod_bit;
    logic [ASCII_W-1:0] asc_tab;
    logic [ASCII_W-1:0] asc_fold;
    logic [ASCII_W-1:0] asc;
    logic [IDX_W-1:0]   wr_next;
    logic [IDX_W-1:0]   rd_next;
    logic               full;
    logic               enq;
    logic               drop;

    assign key      = i_scancode[6:0];
    assign rel      = i_scancode[7];
    assign wr_next  = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
    assign rd_next  = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
    assign full     = (wr_next == r_rd_idx);
    assign o_sts.empty = (r_rd_idx == r_wr_idx);

    always_comb begin
        case (key)
            SC_LSHIFT: mod_bit = MOD_LSHIFT;
            SC_RSHIFT: mod_bit = MOD_RSHIFT;
            SC_CTRL:   mod_bit = MOD_CTRL;
            default:   mod_bit = '0;
        endcase
    end

    // table lookup, case choice by either shift flag
    always_comb begin
        asc_tab = '0;
        if (key < KEY_W'(TABLE_LEN)) begin
            if ((r_mods & (MOD_LSHIFT | MOD_RSHIFT)) != '0) begin
                asc_tab = UPPER_TAB[key[TAB_IDX_W-1:0]];
            end else begin
                asc_tab = LOWER_TAB[key[TAB_IDX_W-1:0]];
            end
        end
    end

    // ctrl turns letters into control codes
    assign asc_fold = asc_tab | CASE_BIT;
    assign asc = ((r_mods & MOD_CTRL) != '0 && asc_fold >= ASCII_LO_A
                  && asc_fold <= ASCII_LO_Z) ? (asc_tab & CTRL_MASK) : asc_tab;

    always_comb begin
        n_mods = r_mods;
        enq    = 1'b0;
        drop   = 1'b0;
        if (i_cmd.scan) begin
            if (mod_bit != '0) begin
                n_mods = rel ? (r_mods & ~mod_bit) : (r_mods | mod_bit);
            end else if (!rel) begin
                enq  = !full;
                drop = full;
            end
        end
    end

    assign n_wr_idx = enq ? wr_next : r_wr_idx;
    assign n_rd_idx = (i_cmd.load_ring && i_cmd.pop) ? rd_next : r_rd_idx;

    assign o_we    = enq;
    assign o_waddr = r_wr_idx;
    assign o_wdata = {key, asc};
    assign o_raddr = r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_mods   <= '0;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_mods   <= n_mods;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan || i_cmd.load_none) begin
            r_key_valid <= 1'b0;
            r_key_scan  <= '0;
            r_key_ascii <= '0;
            r_dropped   <= drop;
        end else if (i_cmd.load_ring) begin
            r_key_valid <= 1'b1;
            r_key_scan  <= i_rdata[WORD_W-1:ASCII_W];
            r_key_ascii <= i_rdata[ASCII_W-1:0];
            r_dropped   <= 1'b0;
        end
    end

    assign o_key_valid = r_key_valid;
    assign o_key_scan  = r_key_scan;
    assign o_key_ascii = r_key_ascii;
    assign o_modifiers = r_mods;
    assign o_dropped   = r_dropped;
endmodule
`default_nettype wire

// File: design/keyboard_scancode_ring_top.sv
// keyboard scancode front end with key ring: top level
//
// input channel (i_valid/o_ready): i_kind selects a scancode event (i_scancode,
// bit 7 marks a release), a read that pops the oldest key word, or a peek
// that only shows it. output channel (o_valid/i_ready): one result per
// transaction with the key word, o_key_valid, the modifier flags after the
// transaction and o_dropped for a press lost to a full ring.
// scancode events, unused kinds and reads of an empty ring give their
// result in the cycle after acceptance; a read or peek of a non-empty ring
// first passes through a read state, for the registered read of the ring ram.
// one transaction is in flight at a time: the next is accepted in the cycle
// after the result is taken.
// the ring holds RING_DEPTH - 1 key words.
// a stalled receiver holds the result steady and the input stays not ready.
// reset clears the ring pointers, the modifier flags and the handshake state;
// the ring ram needs no clearing pass.
`default_nettype none
module keyboard_scancode_ring_top #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [7:0]                    i_scancode,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_key_valid,
    output logic [kbr_pkg::KEY_W-1:0]          o_key_scan,
    output logic [kbr_pkg::ASCII_W-1:0]        o_key_ascii,
    output logic [kbr_pkg::MOD_W-1:0]          o_modifiers,
    output logic                               o_dropped
);
    import kbr_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);

    t_cmd              cmd;
    t_sts              sts;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata;

    kbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    kbr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_scancode  (i_scancode),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_key_valid (o_key_valid),
        .o_key_scan  (o_key_scan),
        .o_key_ascii (o_key_ascii),
        .o_modifiers (o_modifiers),
        .o_dropped   (o_dropped)
    );

    kbr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // one transaction in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a second transaction without a result");

    a_drop_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_dropped && o_key_valid))
        else $error("dropped flag set on a returned key");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_ring |-> !we)
        else $error("ring write during a ring read");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// testbench for keyboard_scancode_ring_top: random scancode, read and peek traffic with a checker
`timescale 1ns / 100ps
module tb_top;
    import kbr_pkg::*;

    localparam int RING_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1530;
    localparam int CALM_LO     = 700;
    localparam int CALM_HI     = 1000;
    localparam int MAX_PRINTS  = 60;

    localparam logic [58*8-1:0] KEYMAP_LOWER = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20
    };
    localparam logic [58*8-1:0] KEYMAP_UPPER = {
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20
    };

    typedef struct packed {
        logic       hold_for_drain;
        t_kind      kind;
        logic [7:0] scancode;
    } t_kbd_req;

    typedef struct packed {
        logic         key_valid;
        logic [6:0]   key_scan;
        logic [7:0]   key_ascii;
        logic [2:0]   modifiers;
        logic         dropped;
    } t_kbd_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [1:0]           i_kind = 2'd0;
    logic [7:0]           i_scancode = 8'd0;
    logic                 i_ready = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_key_valid;
    logic [KEY_W-1:0]     o_key_scan;
    logic [ASCII_W-1:0]   o_key_ascii;
    logic [MOD_W-1:0]     o_modifiers;
    logic                 o_dropped;

    t_kbd_req    pending_keys[$];
    t_kbd_result expected_keys[$];
    logic [14:0] ring_words [RING_DEPTH];
    int          ring_head = 0;
    int          ring_tail = 0;
    logic [2:0]  held_mods = 3'd0;
    int          accepted_cnt = 0;
    int          result_cnt = 0;
    int          error_cnt = 0;
    int          cycle_cnt = 0;
    int          queued_cnt = 0;

    keyboard_scancode_ring_top #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_scancode  (i_scancode),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_key_valid (o_key_valid),
        .o_key_scan  (o_key_scan),
        .o_key_ascii (o_key_ascii),
        .o_modifiers (o_modifiers),
        .o_dropped   (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_kbd_result predict_key(input t_kind kind, input logic [7:0] sc);
        logic [6:0]  key;
        logic [2:0]  mod_bit;
        logic [7:0]  asc;
        int          next_tail;
        t_kbd_result res;
        key     = sc[6:0];
        mod_bit = 3'd0;
        asc     = 8'd0;
        res     = '0;
        case (kind)
            KIND_SCAN: begin
                if (key == SC_LSHIFT) mod_bit = MOD_LSHIFT;
                else if (key == SC_RSHIFT) mod_bit = MOD_RSHIFT;
                else if (key == SC_CTRL) mod_bit = MOD_CTRL;
                if (mod_bit != 3'd0) begin
                    held_mods = sc[7] ? (held_mods & ~mod_bit) : (held_mods | mod_bit);
                end else if (!sc[7]) begin
                    if (key < TABLE_LEN) begin
                        asc = (held_mods & (MOD_LSHIFT | MOD_RSHIFT)) != 3'd0
                            ? KEYMAP_UPPER[(TABLE_LEN - 1 - key) * 8 +: 8]
                            : KEYMAP_LOWER[(TABLE_LEN - 1 - key) * 8 +: 8];
                        if ((held_mods & MOD_CTRL) != 3'd0 && (asc | CASE_BIT) >= ASCII_LO_A
                            && (asc | CASE_BIT) <= ASCII_LO_Z) begin
                            asc = asc & CTRL_MASK;
                        end
                    end
                    next_tail = (ring_tail + 1) % RING_DEPTH;
                    if (next_tail == ring_head) begin
                        res.dropped = 1'b1;
                    end else begin
                        ring_words[ring_tail] = {key, asc};
                        ring_tail = next_tail;
                    end
                end
            end
            KIND_READ, KIND_PEEK: begin
                if (ring_head != ring_tail) begin
                    res.key_valid = 1'b1;
                    {res.key_scan, res.key_ascii} = ring_words[ring_head];
                    if (kind == KIND_READ) ring_head = (ring_head + 1) % RING_DEPTH;
                end
            end
            default: begin
            end
        endcase
        res.modifiers = held_mods;
        return res;
    endfunction

    function automatic bit take_break(input int n);
        return (n < CALM_LO || n > CALM_HI) && ($urandom_range(0, 99) < 11);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_cnt++;
        if (error_cnt <= MAX_PRINTS) begin
            $display("mismatch cycle %0d result %0d: %s got 0x%0h want 0x%0h",
                     cycle_cnt, result_cnt, what, got, want);
        end
    endtask

    task automatic queue_key(input t_kind kind, input logic [7:0] sc);
        t_kbd_req req;
        req.hold_for_drain = 1'b0;
        req.kind           = kind;
        req.scancode       = sc;
        pending_keys.push_back(req);
        queued_cnt++;
    endtask

    task automatic queue_drain();
        t_kbd_req req;
        req = '0;
        req.hold_for_drain = 1'b1;
        pending_keys.push_back(req);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        t_kbd_req next_req;
        logic     drive;
        drive    = 1'b0;
        next_req = '0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_keys.push_back(predict_key(t_kind'(i_kind), i_scancode));
                accepted_cnt++;
            end
            if (!i_valid || o_ready) begin
                if (pending_keys.size() > 0 && pending_keys[0].hold_for_drain) begin
                    if (expected_keys.size() == 0) void'(pending_keys.pop_front());
                end else if (pending_keys.size() > 0 && !take_break(accepted_cnt)) begin
                    drive    = 1'b1;
                    next_req = pending_keys.pop_front();
                end
                i_valid <= drive;
                if (drive) begin
                    i_kind     <= next_req.kind;
                    i_scancode <= next_req.scancode;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_kbd_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                result_cnt++;
                if (expected_keys.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_keys.pop_front();
                    if (o_key_valid !== want.key_valid)
                        report_mismatch("key_valid", o_key_valid, want.key_valid);
                    if (o_key_scan !== want.key_scan)
                        report_mismatch("key_scan", o_key_scan, want.key_scan);
                    if (o_key_ascii !== want.key_ascii)
                        report_mismatch("key_ascii", o_key_ascii, want.key_ascii);
                    if (o_modifiers !== want.modifiers)
                        report_mismatch("modifiers", o_modifiers, want.modifiers);
                    if (o_dropped !== want.dropped)
                        report_mismatch("dropped", o_dropped, want.dropped);
                end
            end
            i_ready <= !take_break(result_cnt);
        end
    end

    initial begin
        int         burst;
        int         pick;
        logic [6:0] key;
        bit         drained_early;
        bit         drained_late;
        drained_early = 1'b0;
        drained_late  = 1'b0;

        // directed: empty ring, unused kind, modifiers, ctrl masking, table edges
        queue_key(KIND_NONE, 8'hFF);
        queue_key(KIND_READ, 8'h00);
        queue_key(KIND_PEEK, 8'hAA);
        queue_key(KIND_SCAN, 8'h00);
        queue_key(KIND_SCAN, 8'h7F);
        queue_key(KIND_SCAN, 8'hFF);
        queue_key(KIND_SCAN, 8'h80);
        queue_key(KIND_SCAN, {1'b0, SC_LSHIFT});
        queue_key(KIND_SCAN, 8'h1E);
        queue_key(KIND_SCAN, 8'h02);
        queue_key(KIND_SCAN, {1'b1, SC_LSHIFT});
        queue_key(KIND_SCAN, {1'b0, SC_RSHIFT});
        queue_key(KIND_SCAN, {1'b0, SC_CTRL});
        queue_key(KIND_SCAN, 8'h1E);
        queue_key(KIND_SCAN, 8'h1A);
        queue_key(KIND_SCAN, 8'h3A);
        queue_key(KIND_SCAN, {1'b1, SC_RSHIFT});
        queue_key(KIND_SCAN, 8'h2C);
        queue_key(KIND_SCAN, {1'b1, SC_CTRL});
        queue_key(KIND_SCAN, 8'h39);
        queue_key(KIND_PEEK, 8'h55);
        queue_key(KIND_READ, 8'hFF);
        queue_drain();

        queued_cnt = 0;
        while (queued_cnt < RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                // typing burst, long enough to overrun the ring at times
                burst = $urandom_range(1, 20);
                repeat (burst) begin
                    case ($urandom_range(0, 2))
                        0: key = SC_LSHIFT;
                        1: key = SC_RSHIFT;
                        default: key = SC_CTRL;
                    endcase
                    if ($urandom_range(0, 7) == 0) begin
                        queue_key(KIND_SCAN, {1'($urandom_range(0, 1)), key});
                    end else begin
                        key = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(58, 127))
                                                         : 7'($urandom_range(0, 57));
                        queue_key(KIND_SCAN, {($urandom_range(0, 9) == 0), key});
                    end
                end
            end else if (pick < 8) begin
                burst = $urandom_range(1, 18);
                repeat (burst) begin
                    queue_key(($urandom_range(0, 3) == 0) ? KIND_PEEK : KIND_READ,
                              8'($urandom));
                end
            end else begin
                burst = $urandom_range(1, 6);
                repeat (burst) queue_key(t_kind'($urandom_range(0, 3)), 8'($urandom));
            end
            if (!drained_early && queued_cnt > 500) begin
                drained_early = 1'b1;
                queue_drain();
            end
            if (!drained_late && queued_cnt > 1100) begin
                drained_late = 1'b1;
                queue_drain();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_keys.size() > 0 || i_valid || expected_keys.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (expected_keys.size() != 0) report_mismatch("missing transactions",
                                                       0, expected_keys.size());
        if (error_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
